// File: hdl/aus_pkg.sv
// ----------------------------------------------------------------------------
// aus_pkg
// Shared types and constants of the Annex-B access unit splitter.
// ----------------------------------------------------------------------------
package aus_pkg;

  // default width of the internal byte offset counter
  localparam int unsigned OFFSET_BITS_DEF = 32;

  // width of the reported offsets
  localparam int unsigned UNIT_OFF_BITS = 32;

  // nal header rules
  localparam logic [4:0] H264_TYPE_MASK  = 5'h1F;
  localparam logic [5:0] H265_TYPE_MASK  = 6'h3F;
  localparam logic [5:0] H265_SLICE_LAST = 6'd31;
  localparam logic [4:0] H264_SLICE_LAST = 5'd5;
  localparam logic [4:0] H264_SLICE_FIRST = 5'd1;

  // start code bytes
  localparam logic [7:0] SC_ZERO_BYTE = 8'h00;
  localparam logic [7:0] SC_ONE_BYTE  = 8'h01;

  // zero run saturates here
  localparam logic [1:0] ZERO_RUN_MAX = 2'd2;

  // output queue depth
  localparam logic [1:0] OUTQ_DEPTH = 2'd2;

  // one result item
  typedef struct packed {
    logic [UNIT_OFF_BITS-1:0] unit_begin_offset;
    logic [UNIT_OFF_BITS-1:0] unit_end_offset;
    logic                     final_unit;
    logic                     offset_overflow;
  } aus_unit_t;

  // results of one stream byte, handed from the parser to the output side
  typedef struct packed {
    logic      close_valid;
    aus_unit_t close_unit;
    logic      final_valid;
    aus_unit_t final_unit;
  } aus_step_res_t;

endpackage

// File: hdl/aus_if.sv
// ----------------------------------------------------------------------------
// aus channel interfaces
// Valid/ready channels for stream bytes, access units and configuration.
// ----------------------------------------------------------------------------
interface aus_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_value;
  logic       end_of_stream;

  modport source (output valid, output byte_value, output end_of_stream, input ready);
  modport sink (input valid, input byte_value, input end_of_stream, output ready);
endinterface

interface aus_unit_if;
  logic        valid;
  logic        ready;
  logic [31:0] unit_begin_offset;
  logic [31:0] unit_end_offset;
  logic        final_unit;
  logic        offset_overflow;

  modport source (output valid, output unit_begin_offset, output unit_end_offset,
                  output final_unit, output offset_overflow, input ready);
  modport sink (input valid, input unit_begin_offset, input unit_end_offset,
                input final_unit, input offset_overflow, output ready);
endinterface

interface aus_cfg_if;
  logic valid;
  logic ready;
  logic codec_is_h265;

  modport source (output valid, output codec_is_h265, input ready);
  modport sink (input valid, input codec_is_h265, output ready);
endinterface

// File: hdl/annexb_access_unit_splitter.sv
// ----------------------------------------------------------------------------
// annexb_access_unit_splitter
// Splits an Annex-B H.264/H.265 byte stream into access unit byte ranges.
// ----------------------------------------------------------------------------
// usage
//   stream : one elementary stream byte per request, end_of_stream on the
//            last byte of a stream; the next byte starts a new stream at 0
//   unit   : one access unit range per request (begin, end, final flag,
//            offset saturation flag), in stream order
//   cfg    : writes codec_is_h265 (0 = H.264, 1 = H.265); always ready,
//            write only while the block is idle
// timing
//   a byte is held in the input register and parsed combinationally there;
//   its results are written into the output queue as it leaves, and unit
//   shows the queue head; throughput is one byte per clock while the output
//   queue has room; a byte that yields two units (a closed unit plus the
//   final unit) needs two free slots in the two-entry output queue, so it
//   waits in the input register until the queue has drained
// reset and stall
//   rst clears the parser state, the queues and the codec register (H.264)
//   when unit stalls, the output queue fills, bytes back up in the input
//   register and stream.ready drops; nothing is dropped or repeated
// ----------------------------------------------------------------------------
module annexb_access_unit_splitter
  import aus_pkg::*;
#(
  parameter int unsigned OFFSET_BITS = OFFSET_BITS_DEF
) (
  input logic  clk,
  input logic  rst,
  aus_byte_if.sink   stream,
  aus_unit_if.source unit,
  aus_cfg_if.sink    cfg
);

  // configuration register
  logic codec_is_h265;

  // input register
  logic       in_full;
  logic [7:0] in_byte;
  logic       in_eos;

  // output queue, head in q0
  aus_unit_t  q0;
  aus_unit_t  q1;
  logic [1:0] q_cnt;

  aus_unit_t  q0_next;
  aus_unit_t  q1_next;
  logic [1:0] q_cnt_next;

  aus_step_res_t res;
  aus_unit_t     r0;
  aus_unit_t     r1;
  logic          pop;
  logic          fire;
  logic [1:0]    need;
  logic [1:0]    cnt_after;
  logic [2:0]    fill_after;
  aus_unit_t     head_after;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      codec_is_h265 <= 1'b0;
    end else if (cfg.valid) begin
      codec_is_h265 <= cfg.codec_is_h265;
    end
  end

  // parser sees the held byte; state advances only when it fires
  aus_parse #(
    .OFFSET_BITS (OFFSET_BITS)
  ) u_parse (
    .clk           (clk),
    .rst           (rst),
    .codec_is_h265 (codec_is_h265),
    .fire          (fire),
    .byte_value    (in_byte),
    .end_of_stream (in_eos),
    .res           (res)
  );

  // results of this byte and the room they need
  assign need       = {1'b0, res.close_valid} + {1'b0, res.final_valid};
  assign pop        = unit.valid && unit.ready;
  assign cnt_after  = q_cnt - {1'b0, pop};
  assign fill_after = {1'b0, cnt_after} + {1'b0, need};
  assign fire       = in_full && (fill_after <= {1'b0, OUTQ_DEPTH});

  // input register takes a new request when empty or being drained
  assign stream.ready = !in_full || fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (stream.ready) begin
      in_full <= stream.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (stream.valid && stream.ready) begin
      in_byte <= stream.byte_value;
      in_eos  <= stream.end_of_stream;
    end
  end

  // pack new results: a closed unit leads, the final unit follows
  always_comb begin
    r0 = res.close_valid ? res.close_unit : res.final_unit;
    r1 = res.final_unit;
    head_after = pop ? q1 : q0;

    if (fire) begin
      case (cnt_after)
        2'd0: begin
          q0_next = r0;
          q1_next = r1;
        end
        2'd1: begin
          q0_next = head_after;
          q1_next = r0;
        end
        default: begin
          q0_next = head_after;
          q1_next = q1;
        end
      endcase
      q_cnt_next = cnt_after + need;
    end else begin
      q0_next    = head_after;
      q1_next    = q1;
      q_cnt_next = cnt_after;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      q_cnt <= '0;
    end else begin
      q_cnt <= q_cnt_next;
    end
  end

  always_ff @(posedge clk) begin
    q0 <= q0_next;
    q1 <= q1_next;
  end

  assign unit.valid             = (q_cnt != 2'd0);
  assign unit.unit_begin_offset = q0.unit_begin_offset;
  assign unit.unit_end_offset   = q0.unit_end_offset;
  assign unit.final_unit        = q0.final_unit;
  assign unit.offset_overflow   = q0.offset_overflow;

endmodule

// File: hdl/aus_parse.sv
// ----------------------------------------------------------------------------
// aus_parse
// Start code detection, nal classification and access unit bookkeeping.
// ----------------------------------------------------------------------------
module aus_parse
  import aus_pkg::*;
#(
  parameter int unsigned OFFSET_BITS = OFFSET_BITS_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          codec_is_h265,
  input  logic          fire,
  input  logic [7:0]    byte_value,
  input  logic          end_of_stream,
  output aus_step_res_t res
);

  localparam logic [OFFSET_BITS-1:0] OFF_MAX = '1;
  localparam logic [OFFSET_BITS-1:0] BACK2   = OFFSET_BITS'(2);
  localparam logic [OFFSET_BITS-1:0] BACK3   = OFFSET_BITS'(3);

  logic [1:0]             zero_run;
  logic                   header_pending;
  logic [OFFSET_BITS-1:0] byte_position;
  logic [OFFSET_BITS-1:0] open_unit_start;
  logic                   open_unit_has_slice;
  logic                   start_code_seen;
  logic                   position_saturated;

  logic [1:0]             zero_run_next;
  logic                   header_pending_next;
  logic [OFFSET_BITS-1:0] byte_position_next;
  logic [OFFSET_BITS-1:0] open_unit_start_next;
  logic                   open_unit_has_slice_next;
  logic                   start_code_seen_next;
  logic                   position_saturated_next;

  logic                   sat_now;
  logic                   is_slice;
  logic                   slice_hdr;
  logic                   closes;
  logic                   sc_found;
  logic [OFFSET_BITS-1:0] sc_off;
  logic [OFFSET_BITS-1:0] first_off;
  logic [OFFSET_BITS-1:0] start_mid;
  logic [OFFSET_BITS-1:0] start_end;
  logic [OFFSET_BITS-1:0] end_off;
  logic [4:0]             t264;
  logic [5:0]             t265;

  always_comb begin
    t264 = byte_value[4:0] & H264_TYPE_MASK;
    t265 = byte_value[6:1] & H265_TYPE_MASK;
    if (codec_is_h265) begin
      is_slice = (t265 <= H265_SLICE_LAST);
    end else begin
      is_slice = (t264 >= H264_SLICE_FIRST) && (t264 <= H264_SLICE_LAST);
    end

    sat_now   = position_saturated || (byte_position == OFF_MAX);
    slice_hdr = header_pending && is_slice;
    closes    = slice_hdr && open_unit_has_slice;
    sc_off    = (byte_position >= BACK3) ? (byte_position - BACK3) : '0;
    first_off = (byte_position >= BACK2) ? (byte_position - BACK2) : '0;
    start_mid = closes ? sc_off : open_unit_start;

    sc_found  = (byte_value == SC_ONE_BYTE) && (zero_run >= ZERO_RUN_MAX);
    start_end = (sc_found && !start_code_seen) ? first_off : start_mid;

    end_off = (byte_position == OFF_MAX) ? OFF_MAX : (byte_position + 1'b1);

    // closed unit comes first, final unit second
    res.close_valid                  = closes;
    res.close_unit.unit_begin_offset = UNIT_OFF_BITS'(open_unit_start);
    res.close_unit.unit_end_offset   = UNIT_OFF_BITS'(sc_off);
    res.close_unit.final_unit        = 1'b0;
    res.close_unit.offset_overflow   = sat_now;

    res.final_valid                  = end_of_stream && (start_code_seen || sc_found);
    res.final_unit.unit_begin_offset = UNIT_OFF_BITS'(start_end);
    res.final_unit.unit_end_offset   = UNIT_OFF_BITS'(end_off);
    res.final_unit.final_unit        = 1'b1;
    res.final_unit.offset_overflow   = sat_now;

    if (byte_value == SC_ZERO_BYTE) begin
      zero_run_next = (zero_run < ZERO_RUN_MAX) ? (zero_run + 1'b1) : zero_run;
    end else begin
      zero_run_next = '0;
    end
    header_pending_next      = sc_found;
    byte_position_next       = end_off;
    open_unit_start_next     = start_end;
    open_unit_has_slice_next = open_unit_has_slice || slice_hdr;
    start_code_seen_next     = start_code_seen || sc_found;
    position_saturated_next  = sat_now;

    // end of stream returns everything to the idle stream state
    if (end_of_stream) begin
      zero_run_next            = '0;
      header_pending_next      = 1'b0;
      byte_position_next       = '0;
      open_unit_start_next     = '0;
      open_unit_has_slice_next = 1'b0;
      start_code_seen_next     = 1'b0;
      position_saturated_next  = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      zero_run            <= '0;
      header_pending      <= 1'b0;
      byte_position       <= '0;
      open_unit_start     <= '0;
      open_unit_has_slice <= 1'b0;
      start_code_seen     <= 1'b0;
      position_saturated  <= 1'b0;
    end else if (fire) begin
      zero_run            <= zero_run_next;
      header_pending      <= header_pending_next;
      byte_position       <= byte_position_next;
      open_unit_start     <= open_unit_start_next;
      open_unit_has_slice <= open_unit_has_slice_next;
      start_code_seen     <= start_code_seen_next;
      position_saturated  <= position_saturated_next;
    end
  end

endmodule
